// ----- hw/rtl/cgtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cgtg_pkg;

  localparam int CFG_W   = 8;
  localparam int IDX_W   = 2;
  localparam int ITEM_W  = 27;
  localparam int INDEX_W = 26;
  localparam int KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CELL,
    KIND_XFACE,
    KIND_YFACE,
    KIND_ZFACE
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CELLS_X,
    REG_CELLS_Y,
    REG_CELLS_Z,
    REG_PLANAR
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_OFS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic sum;
    logic mul2;
    logic ofs;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cgtg_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgtg_cfg #(
  parameter int MAX_CELLS_PER_AXIS = 255,
  localparam int DW = $clog2(MAX_CELLS_PER_AXIS + 2)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [cgtg_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [cgtg_pkg::CFG_W-1:0] cfg_data,
  output logic      [DW-1:0]             nx,
  output logic      [DW-1:0]             ny,
  output logic      [DW-1:0]             nz,
  output logic                           planar
);
  import cgtg_pkg::*;

  logic [CFG_W-1:0] cells_x;
  logic [CFG_W-1:0] cells_y;
  logic [CFG_W-1:0] cells_z;
  logic             planar_mode;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (int'(v) > MAX_CELLS_PER_AXIS) begin
      d = DW'(MAX_CELLS_PER_AXIS);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x     <= CFG_W'(1);
      cells_y     <= CFG_W'(1);
      cells_z     <= CFG_W'(1);
      planar_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_CELLS_X: cells_x <= cfg_data;
        REG_CELLS_Y: cells_y <= cfg_data;
        REG_CELLS_Z: cells_z <= cfg_data;
        REG_PLANAR:  planar_mode <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // In planar mode the grid is one cell deep.
  always_comb begin
    nx     = clamp_dim(cells_x);
    ny     = clamp_dim(cells_y);
    nz     = planar_mode ? DW'(1) : clamp_dim(cells_z);
    planar = planar_mode;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cgtg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgtg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cgtg_pkg::status_t status,
  output cgtg_pkg::cmd_t         cmd
);
  import cgtg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM;
      ST_SUM:  state_next = ST_MUL2;
      ST_MUL2: state_next = ST_OFS;
      ST_OFS:  state_next = ST_OUT;
      ST_OUT:  if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_SUM:  cmd.sum = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_OFS:  cmd.ofs = 1'b1;
      ST_OUT:  cmd.finish = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cgtg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgtg_dp #(
  parameter int MAX_CELLS_PER_AXIS = 255,
  localparam int DW = $clog2(MAX_CELLS_PER_AXIS + 2),
  localparam int PW = $clog2(MAX_CELLS_PER_AXIS + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cgtg_pkg::cmd_t                     cmd,
  output cgtg_pkg::status_t                       status,
  input  wire logic                               restart,
  input  wire logic        [DW-1:0]               nx,
  input  wire logic        [DW-1:0]               ny,
  input  wire logic        [DW-1:0]               nz,
  input  wire logic                               planar,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic             [cgtg_pkg::KIND_W-1:0] entity_kind,
  output logic             [cgtg_pkg::INDEX_W-1:0] entity_index,
  output logic signed      [cgtg_pkg::ITEM_W-1:0] item_a,
  output logic signed      [cgtg_pkg::ITEM_W-1:0] item_b,
  output logic signed      [cgtg_pkg::ITEM_W-1:0] item_c,
  output logic signed      [cgtg_pkg::ITEM_W-1:0] item_d,
  output logic signed      [cgtg_pkg::ITEM_W-1:0] item_e,
  output logic signed      [cgtg_pkg::ITEM_W-1:0] item_f,
  output logic                                    last_entity
);
  import cgtg_pkg::*;

  localparam logic [ITEM_W-1:0] MINUS_ONE = '1;
  localparam logic [ITEM_W-1:0] ONE       = ITEM_W'(1);

  // Walk position.
  logic [PW-1:0] pos_i;
  logic [PW-1:0] pos_j;
  logic [PW-1:0] pos_k;
  kind_t         phase;

  // Position of the entity in flight.
  logic [PW-1:0] ci;
  logic [PW-1:0] cj;
  logic [PW-1:0] ck;
  kind_t         cph;
  logic          clast;

  logic [DW-1:0] nx1;
  logic [DW-1:0] ny1;
  logic [DW-1:0] li;
  logic [DW-1:0] lj;
  logic [DW-1:0] lk;
  logic [DW-1:0] eli;
  logic [DW-1:0] elj;
  logic [DW-1:0] elk;
  logic [DW-1:0] inc_i;
  logic [DW-1:0] inc_j;
  logic [DW-1:0] inc_k;
  kind_t         last_phase;
  logic          bad_pos;
  logic [PW-1:0] ei;
  logic [PW-1:0] ej;
  logic [PW-1:0] ek;
  kind_t         eph;
  logic          wrap_i;
  logic          wrap_j;
  logic          wrap_k;
  logic          last_now;
  logic [PW-1:0] pos_i_next;
  logic [PW-1:0] pos_j_next;
  logic [PW-1:0] pos_k_next;
  kind_t         phase_next;

  logic [ITEM_W-1:0] nxw;
  logic [ITEM_W-1:0] nx1w;

  logic [ITEM_W-1:0] ny_k;
  logic [ITEM_W-1:0] ny1_k;
  logic [ITEM_W-1:0] nx_ny;
  logic [ITEM_W-1:0] nx1_ny1;
  logic [ITEM_W-1:0] nx1_ny;
  logic [ITEM_W-1:0] nx_ny1;
  logic [ITEM_W-1:0] row_c;
  logic [ITEM_W-1:0] row_n;
  logic [ITEM_W-1:0] xf_count;
  logic [ITEM_W-1:0] yf_count;
  logic [ITEM_W-1:0] nx_rc;
  logic [ITEM_W-1:0] nx1_rc;
  logic [ITEM_W-1:0] nx_rn;
  logic [ITEM_W-1:0] nx1_rn;
  logic [ITEM_W-1:0] xyf_count;
  logic [ITEM_W-1:0] cell_ofs;
  logic [ITEM_W-1:0] node_ofs;
  logic [ITEM_W-1:0] cell_n;
  logic [ITEM_W-1:0] node_base;

  logic [ITEM_W-1:0] r_idx;
  logic [ITEM_W-1:0] r_a;
  logic [ITEM_W-1:0] r_b;
  logic [ITEM_W-1:0] r_c;
  logic [ITEM_W-1:0] r_d;
  logic [ITEM_W-1:0] r_e;
  logic [ITEM_W-1:0] r_f;

  assign nx1  = nx + DW'(1);
  assign ny1  = ny + DW'(1);
  assign nxw  = ITEM_W'(nx);
  assign nx1w = ITEM_W'(nx1);

  // The restart input, or a position or phase that no longer fits the grid, restarts the walk.
  always_comb begin
    last_phase = planar ? KIND_YFACE : KIND_ZFACE;
    li = (phase == KIND_XFACE) ? nx1 : nx;
    lj = (phase == KIND_YFACE) ? ny1 : ny;
    lk = (phase == KIND_ZFACE) ? (nz + DW'(1)) : nz;
    bad_pos = restart || (phase > last_phase) || (DW'(pos_i) >= li) ||
              (DW'(pos_j) >= lj) || (DW'(pos_k) >= lk);
    if (bad_pos) begin
      ei  = '0;
      ej  = '0;
      ek  = '0;
      eph = KIND_CELL;
    end else begin
      ei  = pos_i;
      ej  = pos_j;
      ek  = pos_k;
      eph = phase;
    end
    eli = (eph == KIND_XFACE) ? nx1 : nx;
    elj = (eph == KIND_YFACE) ? ny1 : ny;
    elk = (eph == KIND_ZFACE) ? (nz + DW'(1)) : nz;
    inc_i  = DW'(ei) + DW'(1);
    inc_j  = DW'(ej) + DW'(1);
    inc_k  = DW'(ek) + DW'(1);
    wrap_i = inc_i >= eli;
    wrap_j = inc_j >= elj;
    wrap_k = inc_k >= elk;
    last_now   = 1'b0;
    pos_i_next = PW'(inc_i);
    pos_j_next = ej;
    pos_k_next = ek;
    phase_next = eph;
    if (wrap_i) begin
      pos_i_next = '0;
      pos_j_next = PW'(inc_j);
      if (wrap_j) begin
        pos_j_next = '0;
        pos_k_next = PW'(inc_k);
        if (wrap_k) begin
          pos_k_next = '0;
          if (eph == last_phase) begin
            last_now   = 1'b1;
            phase_next = KIND_CELL;
          end else begin
            phase_next = kind_t'(eph + KIND_W'(1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_i <= '0;
      pos_j <= '0;
      pos_k <= '0;
      phase <= KIND_CELL;
    end else if (cmd.load) begin
      pos_i <= pos_i_next;
      pos_j <= pos_j_next;
      pos_k <= pos_k_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ci    <= ei;
      cj    <= ej;
      ck    <= ek;
      cph   <= eph;
      clast <= last_now;
    end
    if (cmd.mul1) begin
      ny_k    <= ITEM_W'(ny) * ITEM_W'(ck);
      ny1_k   <= ITEM_W'(ny1) * ITEM_W'(ck);
      nx_ny   <= nxw * ITEM_W'(ny);
      nx1_ny1 <= nx1w * ITEM_W'(ny1);
      nx1_ny  <= nx1w * ITEM_W'(ny);
      nx_ny1  <= nxw * ITEM_W'(ny1);
    end
    if (cmd.sum) begin
      row_c    <= ITEM_W'(cj) + ny_k;
      row_n    <= ITEM_W'(cj) + ny1_k;
      xf_count <= nx1_ny * ITEM_W'(nz);
      yf_count <= nx_ny1 * ITEM_W'(nz);
    end
    if (cmd.mul2) begin
      nx_rc     <= nxw * row_c;
      nx1_rc    <= nx1w * row_c;
      nx_rn     <= nxw * row_n;
      nx1_rn    <= nx1w * row_n;
      xyf_count <= xf_count + yf_count;
    end
    if (cmd.ofs) begin
      cell_ofs  <= ITEM_W'(ci) + nx_rc;
      node_ofs  <= ITEM_W'(ci) + nx1_rc;
      cell_n    <= ITEM_W'(ci) + nx_rn;
      node_base <= ITEM_W'(ci) + nx1_rn;
    end
  end

  always_comb begin
    r_idx = cell_ofs;
    r_a   = '0;
    r_b   = '0;
    r_c   = '0;
    r_d   = '0;
    r_e   = '0;
    r_f   = '0;
    case (cph)
      KIND_CELL: begin
        r_idx = cell_ofs;
        if (planar) begin
          r_a = node_ofs;
          r_b = cell_ofs + xf_count;
          r_c = node_ofs + ONE;
          r_d = cell_ofs + nxw + xf_count;
        end else begin
          r_a = node_ofs;
          r_b = node_ofs + ONE;
          r_c = cell_n + xf_count;
          r_d = cell_n + nxw + xf_count;
          r_e = cell_ofs + xyf_count;
          r_f = cell_ofs + nx_ny + xyf_count;
        end
      end
      KIND_XFACE: begin
        r_idx = node_ofs;
        if (planar) begin
          r_a = node_ofs;
          r_b = node_ofs + nx1w;
        end else begin
          r_a = node_base;
          r_b = node_base + nx1w;
          r_c = node_base + nx1w + nx1_ny1;
          r_d = node_base + nx1_ny1;
        end
        r_e = (ci != '0) ? (cell_ofs - ONE) : MINUS_ONE;
        r_f = (DW'(ci) < nx) ? cell_ofs : MINUS_ONE;
      end
      KIND_YFACE: begin
        r_idx = xf_count + cell_n;
        if (planar) begin
          r_a = node_ofs + ONE;
          r_b = node_ofs;
        end else begin
          r_a = node_base;
          r_b = node_base + nx1_ny1;
          r_c = node_base + nx1_ny1 + ONE;
          r_d = node_base + ONE;
        end
        r_e = (cj != '0) ? (cell_ofs - nxw) : MINUS_ONE;
        r_f = (DW'(cj) < ny) ? cell_ofs : MINUS_ONE;
      end
      KIND_ZFACE: begin
        r_idx = xyf_count + cell_ofs;
        r_a   = node_base;
        r_b   = node_base + ONE;
        r_c   = node_base + ONE + nx1w;
        r_d   = node_base + nx1w;
        r_e   = (ck != '0) ? (cell_ofs - nx_ny) : MINUS_ONE;
        r_f   = (DW'(ck) < nz) ? cell_ofs : MINUS_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      entity_kind  <= cph;
      entity_index <= r_idx[INDEX_W-1:0];
      item_a       <= r_a;
      item_b       <= r_b;
      item_c       <= r_c;
      item_d       <= r_d;
      item_e       <= r_e;
      item_f       <= r_f;
      last_entity  <= clast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/cartesian_grid_topology_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     restart
// output    out_valid / out_ready   entity_kind, entity_index, item_a .. item_f,
//                                   last_entity
// config    cfg_write               cfg_index, cfg_data
//
// Between one input acceptance and the next, the controller walks the first multiply,
// the sum, the second multiply, the offset adds and the output step, then idles.
// The result is registered; the next input is taken while it waits to be taken.
// Reset is synchronous; it clears the walk position and loads the default grid.
// A stalled output holds the controller in its final state until it drains.

module cartesian_grid_topology_generator_core #(
  parameter int MAX_CELLS_PER_AXIS = 255
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic        [cgtg_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic        [cgtg_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                restart,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [cgtg_pkg::KIND_W-1:0]  entity_kind,
  output logic             [cgtg_pkg::INDEX_W-1:0] entity_index,
  output logic signed      [cgtg_pkg::ITEM_W-1:0]  item_a,
  output logic signed      [cgtg_pkg::ITEM_W-1:0]  item_b,
  output logic signed      [cgtg_pkg::ITEM_W-1:0]  item_c,
  output logic signed      [cgtg_pkg::ITEM_W-1:0]  item_d,
  output logic signed      [cgtg_pkg::ITEM_W-1:0]  item_e,
  output logic signed      [cgtg_pkg::ITEM_W-1:0]  item_f,
  output logic                                     last_entity
);
  import cgtg_pkg::*;

  localparam int DW = $clog2(MAX_CELLS_PER_AXIS + 2);

  logic [DW-1:0] nx;
  logic [DW-1:0] ny;
  logic [DW-1:0] nz;
  logic          planar;
  cmd_t          cmd;
  status_t       status;

  cgtg_cfg #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .nx       (nx),
    .ny       (ny),
    .nz       (nz),
    .planar   (planar)
  );

  cgtg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  cgtg_dp #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .restart     (restart),
    .nx          (nx),
    .ny          (ny),
    .nz          (nz),
    .planar      (planar),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .entity_kind (entity_kind),
    .entity_index(entity_index),
    .item_a      (item_a),
    .item_b      (item_b),
    .item_c      (item_c),
    .item_d      (item_d),
    .item_e      (item_e),
    .item_f      (item_f),
    .last_entity (last_entity)
  );

endmodule

`default_nettype wire
